>>> design/skwl_pkg.sv
// shared types and constants for the sorted key window locator
// no dependencies; used by every module of the block but skwl_ram
package skwl_pkg;

  localparam int GROUP_DEPTH_DEF  = 1024;
  localparam int MAX_ELEMENTS_DEF = 65536;

  localparam int KEY_W     = 32;
  localparam int SIZE_W    = 17;
  localparam int CMD_W     = 2;
  localparam int WSTART_W  = 16;
  localparam int WSIZE_W   = 17;
  localparam int CFG_IDX_W = 2;

  // stream packing
  localparam int S_TDATA_W = 120;
  localparam int M_TDATA_W = 40;

  localparam int S_KEY_LSB   = 0;
  localparam int S_SIZE_LSB  = S_KEY_LSB + KEY_W;
  localparam int S_START_LSB = S_SIZE_LSB + SIZE_W;
  localparam int S_STOP_LSB  = S_START_LSB + KEY_W;

  localparam int M_WSTART_LSB = 0;
  localparam int M_WSIZE_LSB  = M_WSTART_LSB + WSTART_W;
  localparam int M_USED_W     = M_WSIZE_LSB + WSIZE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_UNBOUNDED  = 2'd0,
    CFG_STOP_UNBOUNDED   = 2'd1,
    CFG_REQUIRE_COMPLETE = 2'd2
  } cfg_index_t;

  // operands and flags of the shared key comparator
  typedef struct packed {
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic lt;
    logic le;
  } cmp_res_t;

endpackage

>>> design/skwl_ram.sv
// generic single write port ram with registered read
// no dependencies
module skwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/skwl_cmp.sv
// shared signed key comparator, reused by the append, check and walk steps of the sequencer
// depends on skwl_pkg
module skwl_cmp (
  input  skwl_pkg::cmp_req_t req,
  output skwl_pkg::cmp_res_t res
);

  logic signed [skwl_pkg::KEY_W-1:0] a;
  logic signed [skwl_pkg::KEY_W-1:0] b;

  assign a = $signed(req.a);
  assign b = $signed(req.b);

  always_comb begin
    res.lt = a < b;
    res.le = a <= b;
  end

endmodule

>>> design/skwl_seq.sv
// sequencer: table append, completeness check, forward pointer walks, window lookup
// depends on skwl_pkg; drives the key and position rams and the shared comparator
module skwl_seq #(
  parameter int GROUP_DEPTH  = skwl_pkg::GROUP_DEPTH_DEF,
  parameter int MAX_ELEMENTS = skwl_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [skwl_pkg::CMD_W-1:0]      cmd,
  input  logic [skwl_pkg::KEY_W-1:0]      key,
  input  logic [skwl_pkg::SIZE_W-1:0]     group_size,
  input  logic [skwl_pkg::KEY_W-1:0]      range_start,
  input  logic [skwl_pkg::KEY_W-1:0]      range_stop,
  input  logic                            lo_open,
  input  logic                            hi_open,
  input  logic                            require_complete,
  output skwl_pkg::cmp_req_t              cmp_req,
  input  skwl_pkg::cmp_res_t              cmp_res,
  output logic                            tbl_we,
  output logic [$clog2(GROUP_DEPTH)-1:0]  tbl_waddr,
  output logic [$clog2(GROUP_DEPTH)-1:0]  tbl_raddr,
  output logic [skwl_pkg::KEY_W-1:0]      key_wdata,
  input  logic [skwl_pkg::KEY_W-1:0]      key_rdata,
  output logic [2*$clog2(MAX_ELEMENTS)-1:0] pos_wdata,
  input  logic [2*$clog2(MAX_ELEMENTS)-1:0] pos_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [skwl_pkg::WSTART_W-1:0]   win_base,
  output logic [skwl_pkg::WSIZE_W-1:0]    win_count,
  output logic                            skipped
);

  localparam int AW = $clog2(GROUP_DEPTH);
  localparam int CW = $clog2(GROUP_DEPTH + 1);
  localparam int TW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = $clog2(MAX_ELEMENTS);
  localparam int SW = ((TW > skwl_pkg::SIZE_W) ? TW : skwl_pkg::SIZE_W) + 1;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_APPEND = 14'b00000000000010,
    ST_CHK_LO = 14'b00000000000100,
    ST_CHK_HI = 14'b00000000001000,
    ST_FIRST  = 14'b00000000010000,
    ST_S_RD   = 14'b00000000100000,
    ST_S_CMP  = 14'b00000001000000,
    ST_LAST   = 14'b00000010000000,
    ST_T_RD   = 14'b00000100000000,
    ST_T_CMP  = 14'b00001000000000,
    ST_WIN    = 14'b00010000000000,
    ST_P_RD_L = 14'b00100000000000,
    ST_P_FIN  = 14'b01000000000000,
    ST_RESULT = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] group_count, group_count_next;
  logic [TW-1:0] element_total, element_total_next;
  logic [CW-1:0] start_ptr, start_ptr_next;
  logic [CW-1:0] stop_ptr, stop_ptr_next;
  logic [CW-1:0] first_idx, first_idx_next;
  logic [CW-1:0] last_idx1, last_idx1_next;  // last group index plus one, zero for none

  logic [skwl_pkg::KEY_W-1:0]  first_key, first_key_next;
  logic [skwl_pkg::KEY_W-1:0]  last_key, last_key_next;
  logic [skwl_pkg::KEY_W-1:0]  key_q, key_q_next;
  logic [skwl_pkg::SIZE_W-1:0] size_q, size_q_next;
  logic [skwl_pkg::KEY_W-1:0]  lo_q, lo_q_next;
  logic [skwl_pkg::KEY_W-1:0]  hi_q, hi_q_next;
  logic [PW-1:0]               ws_pos, ws_pos_next;

  logic [skwl_pkg::WSTART_W-1:0] res_start, res_start_next;
  logic [skwl_pkg::WSIZE_W-1:0]  res_size, res_size_next;
  logic                          res_skip, res_skip_next;

  logic [SW-1:0] sum;
  logic [SW-1:0] sum_m1;
  logic          drop;
  logic [CW-1:0] start_ptr_inc;
  logic [CW-1:0] stop_ptr_inc;
  logic [CW-1:0] last_idx;
  logic [PW-1:0] end_pos;
  logic [PW:0]   win_len;
  logic [PW+skwl_pkg::WSTART_W-1:0] ws_ext;
  logic [PW+skwl_pkg::WSIZE_W:0]    wn_ext;

  assign sum = SW'(element_total) + SW'(size_q);
  assign sum_m1 = sum - SW'(1);
  assign start_ptr_inc = start_ptr + CW'(1);
  assign stop_ptr_inc = stop_ptr + CW'(1);
  assign last_idx = last_idx1 - CW'(1);
  assign end_pos = pos_rdata[2*PW-1:PW];
  assign win_len = {1'b0, end_pos} - {1'b0, ws_pos} + (PW+1)'(1);
  assign ws_ext = {{skwl_pkg::WSTART_W{1'b0}}, ws_pos};
  assign wn_ext = {{skwl_pkg::WSIZE_W{1'b0}}, win_len};

  // drop rules of an append, key order uses the comparator result
  assign drop = (group_count == CW'(GROUP_DEPTH)) || (size_q == '0) ||
                (sum > SW'(MAX_ELEMENTS)) ||
                ((group_count != '0) && !cmp_res.lt);

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_RESULT);
  assign win_base = res_start;
  assign win_count = res_size;
  assign skipped = res_skip;

  assign tbl_waddr = group_count[AW-1:0];
  assign key_wdata = key_q;
  assign pos_wdata = {sum_m1[PW-1:0], element_total[PW-1:0]};

  always_comb begin
    state_next = state;
    group_count_next = group_count;
    element_total_next = element_total;
    start_ptr_next = start_ptr;
    stop_ptr_next = stop_ptr;
    first_idx_next = first_idx;
    last_idx1_next = last_idx1;
    first_key_next = first_key;
    last_key_next = last_key;
    key_q_next = key_q;
    size_q_next = size_q;
    lo_q_next = lo_q;
    hi_q_next = hi_q;
    ws_pos_next = ws_pos;
    res_start_next = res_start;
    res_size_next = res_size;
    res_skip_next = res_skip;
    tbl_we = 1'b0;
    tbl_raddr = start_ptr[AW-1:0];
    cmp_req.a = key_rdata;
    cmp_req.b = lo_q;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          key_q_next = key;
          size_q_next = group_size;
          lo_q_next = range_start;
          hi_q_next = range_stop;
          unique case (cmd)
            skwl_pkg::CMD_CLEAR: begin
              group_count_next = '0;
              element_total_next = '0;
              start_ptr_next = '0;
              stop_ptr_next = '0;
            end
            skwl_pkg::CMD_APPEND: state_next = ST_APPEND;
            skwl_pkg::CMD_QUERY:  state_next = ST_CHK_LO;
            default: state_next = ST_IDLE;
          endcase
        end
      end

      ST_APPEND: begin
        cmp_req.a = last_key;
        cmp_req.b = key_q;
        if (!drop) begin
          tbl_we = 1'b1;
          group_count_next = group_count + CW'(1);
          element_total_next = sum[TW-1:0];
          last_key_next = key_q;
          if (group_count == '0) begin
            first_key_next = key_q;
          end
        end
        state_next = ST_IDLE;
      end

      ST_CHK_LO: begin
        cmp_req.a = lo_q;
        cmp_req.b = first_key;
        if (require_complete && (group_count != '0) && !lo_open && cmp_res.lt) begin
          res_start_next = '0;
          res_size_next = '0;
          res_skip_next = 1'b1;
          state_next = ST_RESULT;
        end else begin
          state_next = ST_CHK_HI;
        end
      end

      ST_CHK_HI: begin
        cmp_req.a = last_key;
        cmp_req.b = hi_q;
        if (require_complete && (group_count != '0) && !hi_open && cmp_res.lt) begin
          res_start_next = '0;
          res_size_next = '0;
          res_skip_next = 1'b1;
          state_next = ST_RESULT;
        end else begin
          state_next = ST_FIRST;
        end
      end

      ST_FIRST: begin
        if (lo_open) begin
          first_idx_next = '0;
          state_next = ST_LAST;
        end else if (start_ptr >= group_count) begin
          first_idx_next = group_count;
          state_next = ST_LAST;
        end else begin
          state_next = ST_S_RD;
        end
      end

      ST_S_RD: begin
        tbl_raddr = start_ptr[AW-1:0];
        state_next = ST_S_CMP;
      end

      // start pointer passes keys below the range start
      ST_S_CMP: begin
        cmp_req.a = key_rdata;
        cmp_req.b = lo_q;
        if (cmp_res.lt) begin
          start_ptr_next = start_ptr_inc;
          if (start_ptr_inc >= group_count) begin
            first_idx_next = group_count;
            state_next = ST_LAST;
          end else begin
            state_next = ST_S_RD;
          end
        end else begin
          first_idx_next = start_ptr;
          state_next = ST_LAST;
        end
      end

      ST_LAST: begin
        if (hi_open || (stop_ptr >= group_count)) begin
          last_idx1_next = group_count;
          state_next = ST_WIN;
        end else begin
          state_next = ST_T_RD;
        end
      end

      ST_T_RD: begin
        tbl_raddr = stop_ptr[AW-1:0];
        state_next = ST_T_CMP;
      end

      // stop pointer passes keys at or below the range stop
      ST_T_CMP: begin
        cmp_req.a = key_rdata;
        cmp_req.b = hi_q;
        if (cmp_res.le) begin
          stop_ptr_next = stop_ptr_inc;
          if (stop_ptr_inc >= group_count) begin
            last_idx1_next = group_count;
            state_next = ST_WIN;
          end else begin
            state_next = ST_T_RD;
          end
        end else begin
          last_idx1_next = stop_ptr;
          state_next = ST_WIN;
        end
      end

      ST_WIN: begin
        tbl_raddr = first_idx[AW-1:0];
        if (last_idx1 > first_idx) begin
          state_next = ST_P_RD_L;
        end else begin
          res_start_next = '0;
          res_size_next = '0;
          res_skip_next = 1'b0;
          state_next = ST_RESULT;
        end
      end

      ST_P_RD_L: begin
        ws_pos_next = pos_rdata[PW-1:0];
        tbl_raddr = last_idx[AW-1:0];
        state_next = ST_P_FIN;
      end

      ST_P_FIN: begin
        res_start_next = ws_ext[skwl_pkg::WSTART_W-1:0];
        res_size_next = wn_ext[skwl_pkg::WSIZE_W-1:0];
        res_skip_next = 1'b0;
        state_next = ST_RESULT;
      end

      ST_RESULT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      group_count <= '0;
      element_total <= '0;
      start_ptr <= '0;
      stop_ptr <= '0;
    end else begin
      state <= state_next;
      group_count <= group_count_next;
      element_total <= element_total_next;
      start_ptr <= start_ptr_next;
      stop_ptr <= stop_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    first_idx <= first_idx_next;
    last_idx1 <= last_idx1_next;
    first_key <= first_key_next;
    last_key <= last_key_next;
    key_q <= key_q_next;
    size_q <= size_q_next;
    lo_q <= lo_q_next;
    hi_q <= hi_q_next;
    ws_pos <= ws_pos_next;
    res_start <= res_start_next;
    res_size <= res_size_next;
    res_skip <= res_skip_next;
  end

endmodule

>>> design/sorted_key_window_locator.sv
// Sorted key window locator. Requests arrive on the s_ stream with the command in
// s_tuser: clear empties the table without leaving idle, append stores a strictly
// larger key and its group size (dropped when the table or element space is full,
// the size is zero or the key is not increasing), and a query answers on the m_ stream
// with the element window of all groups whose keys lie in [range_start, range_stop].
// A query or an append occupies the sequencer until it is done, a skipped query ends
// before the walks, and a result that cannot leave holds the sequencer. The block uses
// one signed comparator and a single registered read port on the key and position
// tables. The pointers only move forward (a clear rewinds them), so with nondecreasing
// bounds the walk costs a few compares per query across a stream. One result can wait
// in the output register while the next request is accepted. Configuration writes
// take effect at once and are meant for idle periods.
// top level; depends on skwl_pkg, skwl_ram, skwl_cmp, skwl_seq
module sorted_key_window_locator #(
  parameter int GROUP_DEPTH  = skwl_pkg::GROUP_DEPTH_DEF,
  parameter int MAX_ELEMENTS = skwl_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // key[31:0], group_size[48:32], range_start[80:49], range_stop[112:81], zero pad
  input  logic [skwl_pkg::S_TDATA_W-1:0]    s_tdata,
  // cmd[1:0]
  input  logic [skwl_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // win_base[15:0], win_count[32:16], zero pad
  output logic [skwl_pkg::M_TDATA_W-1:0]    m_tdata,
  // skipped[0]
  output logic [0:0]                        m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [skwl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic                              cfg_data
);

  localparam int AW = $clog2(GROUP_DEPTH);
  localparam int PW = $clog2(MAX_ELEMENTS);

  logic lo_open;
  logic hi_open;
  logic require_complete;

  skwl_pkg::cmp_req_t cmp_req;
  skwl_pkg::cmp_res_t cmp_res;

  logic                          tbl_we;
  logic [AW-1:0]                 tbl_waddr;
  logic [AW-1:0]                 tbl_raddr;
  logic [skwl_pkg::KEY_W-1:0]    key_wdata;
  logic [skwl_pkg::KEY_W-1:0]    key_rdata;
  logic [2*PW-1:0]               pos_wdata;
  logic [2*PW-1:0]               pos_rdata;

  logic                          res_valid;
  logic                          res_ready;
  logic [skwl_pkg::WSTART_W-1:0] win_base;
  logic [skwl_pkg::WSIZE_W-1:0]  win_count;
  logic                          skipped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_open <= 1'b0;
      hi_open <= 1'b0;
      require_complete <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        skwl_pkg::CFG_START_UNBOUNDED:  lo_open <= cfg_data;
        skwl_pkg::CFG_STOP_UNBOUNDED:   hi_open <= cfg_data;
        skwl_pkg::CFG_REQUIRE_COMPLETE: require_complete <= cfg_data;
        default: ;
      endcase
    end
  end

  skwl_cmp u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

  skwl_ram #(
    .WIDTH (skwl_pkg::KEY_W),
    .DEPTH (GROUP_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (key_wdata),
    .raddr (tbl_raddr),
    .rdata (key_rdata)
  );

  // first and last element position of each group, last in the upper half
  skwl_ram #(
    .WIDTH (2*PW),
    .DEPTH (GROUP_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (pos_wdata),
    .raddr (tbl_raddr),
    .rdata (pos_rdata)
  );

  skwl_seq #(
    .GROUP_DEPTH  (GROUP_DEPTH),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (s_tvalid),
    .req_ready        (s_tready),
    .cmd              (s_tuser),
    .key              (s_tdata[skwl_pkg::S_KEY_LSB +: skwl_pkg::KEY_W]),
    .group_size       (s_tdata[skwl_pkg::S_SIZE_LSB +: skwl_pkg::SIZE_W]),
    .range_start      (s_tdata[skwl_pkg::S_START_LSB +: skwl_pkg::KEY_W]),
    .range_stop       (s_tdata[skwl_pkg::S_STOP_LSB +: skwl_pkg::KEY_W]),
    .lo_open          (lo_open),
    .hi_open          (hi_open),
    .require_complete (require_complete),
    .cmp_req          (cmp_req),
    .cmp_res          (cmp_res),
    .tbl_we           (tbl_we),
    .tbl_waddr        (tbl_waddr),
    .tbl_raddr        (tbl_raddr),
    .key_wdata        (key_wdata),
    .key_rdata        (key_rdata),
    .pos_wdata        (pos_wdata),
    .pos_rdata        (pos_rdata),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .win_base         (win_base),
    .win_count        (win_count),
    .skipped          (skipped)
  );

  // output register, refilled in the cycle the waiting result is taken
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {{(skwl_pkg::M_TDATA_W - skwl_pkg::M_USED_W){1'b0}}, win_count, win_base};
      m_tuser <= skipped;
    end
  end

  a_skip_empty : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[skwl_pkg::M_USED_W-1:0] == '0)
    else $error("skipped query carries a nonempty window");

  a_query_busy : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == skwl_pkg::CMD_QUERY) |=> !s_tready)
    else $error("query request did not occupy the sequencer");

  a_clear_fast : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == skwl_pkg::CMD_CLEAR) |=> s_tready)
    else $error("clear request did not finish in one cycle");

endmodule
